### design/aafu_pkg.sv
// package for the accumulator alu and flag unit
// command codes, architectural state type and status packing; no dependencies
package aafu_pkg;

    localparam int CMD_W    = 6;
    localparam int BYTE_W   = 8;
    localparam int S_DATA_W = 16;
    localparam int M_DATA_W = 48;

    localparam logic [BYTE_W-1:0] SIGN_MASK = 8'h80;
    localparam logic [BYTE_W-1:0] OVF_MASK  = 8'h40;
    localparam logic [BYTE_W-1:0] LSB_MASK  = 8'h01;

    typedef enum logic [CMD_W-1:0] {
        CMD_ORA = 6'd0,
        CMD_AND = 6'd1,
        CMD_EOR = 6'd2,
        CMD_ADC = 6'd3,
        CMD_SBC = 6'd4,
        CMD_CMP = 6'd5,
        CMD_CPX = 6'd6,
        CMD_CPY = 6'd7,
        CMD_BIT = 6'd8,
        CMD_LDA = 6'd9,
        CMD_LDX = 6'd10,
        CMD_LDY = 6'd11,
        CMD_STA = 6'd12,
        CMD_STX = 6'd13,
        CMD_STY = 6'd14,
        CMD_ASL = 6'd15,
        CMD_LSR = 6'd16,
        CMD_ROL = 6'd17,
        CMD_ROR = 6'd18,
        CMD_INC = 6'd19,
        CMD_DEC = 6'd20,
        CMD_TAX = 6'd21,
        CMD_TAY = 6'd22,
        CMD_TXA = 6'd23,
        CMD_TYA = 6'd24,
        CMD_INX = 6'd25,
        CMD_DEX = 6'd26,
        CMD_INY = 6'd27,
        CMD_DEY = 6'd28,
        CMD_CLC = 6'd29,
        CMD_SEC = 6'd30,
        CMD_CLV = 6'd31,
        CMD_CLD = 6'd32,
        CMD_SED = 6'd33,
        CMD_CLI = 6'd34,
        CMD_SEI = 6'd35,
        CMD_NOP = 6'd36
    } cmd_t;

    typedef struct packed {
        logic [BYTE_W-1:0] acc;
        logic [BYTE_W-1:0] x;
        logic [BYTE_W-1:0] y;
        logic              n;
        logic              v;
        logic              d;
        logic              i;
        logic              z;
        logic              c;
    } arch_t;

    typedef struct packed {
        logic [BYTE_W-1:0] write_data;
        logic              write_valid;
    } mem_wr_t;

    function automatic logic [BYTE_W-1:0] pack_status(input arch_t st);
        return {st.n, st.v, 2'b00, st.d, st.i, st.z, st.c};
    endfunction

endpackage

### design/aafu_alu.sv
// combinational execute logic: one command against the current architectural state
// gives the next state and the memory write; depends on aafu_pkg
module aafu_alu (
    input  logic [aafu_pkg::CMD_W-1:0]  command,
    input  logic [aafu_pkg::BYTE_W-1:0] operand,
    input  logic                        on_accumulator,
    input  aafu_pkg::arch_t             cur,
    output aafu_pkg::arch_t             nxt,
    output aafu_pkg::mem_wr_t           wr
);
    import aafu_pkg::*;

    cmd_t              cmd;
    logic [BYTE_W-1:0] add_rhs;
    logic [BYTE_W:0]   add_sum;
    logic [BYTE_W-1:0] add_res;
    logic [BYTE_W-1:0] cmp_lhs;
    logic [BYTE_W:0]   cmp_diff;
    logic [BYTE_W-1:0] sh_src;
    logic [BYTE_W-1:0] sh_res;
    logic              sh_carry;
    logic [BYTE_W-1:0] nz_val;
    logic              nz_upd;

    assign cmd      = cmd_t'(command);
    assign add_rhs  = (cmd == CMD_SBC) ? ~operand : operand;
    assign add_sum  = {1'b0, cur.acc} + {1'b0, add_rhs} + {{BYTE_W{1'b0}}, cur.c};
    assign add_res  = add_sum[BYTE_W-1:0];
    assign cmp_lhs  = (cmd == CMD_CPX) ? cur.x : ((cmd == CMD_CPY) ? cur.y : cur.acc);
    assign cmp_diff = {1'b0, cmp_lhs} - {1'b0, operand};
    assign sh_src   = on_accumulator ? cur.acc : operand;

    always_comb
    begin
        case (cmd)
            CMD_ASL:
            begin
                sh_res   = {sh_src[BYTE_W-2:0], 1'b0};
                sh_carry = |(sh_src & SIGN_MASK);
            end
            CMD_ROL:
            begin
                sh_res   = {sh_src[BYTE_W-2:0], cur.c};
                sh_carry = |(sh_src & SIGN_MASK);
            end
            CMD_LSR:
            begin
                sh_res   = {1'b0, sh_src[BYTE_W-1:1]};
                sh_carry = |(sh_src & LSB_MASK);
            end
            default:
            begin
                sh_res   = {cur.c, sh_src[BYTE_W-1:1]};
                sh_carry = |(sh_src & LSB_MASK);
            end
        endcase
    end

    always_comb
    begin
        nxt            = cur;
        wr.write_data  = '0;
        wr.write_valid = 1'b0;
        nz_val         = '0;
        nz_upd         = 1'b0;
        case (cmd)
            CMD_ORA:
            begin
                nxt.acc = cur.acc | operand;
                nz_val  = nxt.acc;
                nz_upd  = 1'b1;
            end
            CMD_AND:
            begin
                nxt.acc = cur.acc & operand;
                nz_val  = nxt.acc;
                nz_upd  = 1'b1;
            end
            CMD_EOR:
            begin
                nxt.acc = cur.acc ^ operand;
                nz_val  = nxt.acc;
                nz_upd  = 1'b1;
            end
            CMD_ADC, CMD_SBC:
            begin
                nxt.acc = add_res;
                nxt.c   = add_sum[BYTE_W];
                nxt.v   = |(((cur.acc ^ add_res) & (add_rhs ^ add_res)) & SIGN_MASK);
                nz_val  = add_res;
                nz_upd  = 1'b1;
            end
            CMD_CMP, CMD_CPX, CMD_CPY:
            begin
                nxt.c  = ~cmp_diff[BYTE_W];
                nz_val = cmp_diff[BYTE_W-1:0];
                nz_upd = 1'b1;
            end
            CMD_BIT:
            begin
                nxt.z = ((cur.acc & operand) == '0);
                nxt.n = |(operand & SIGN_MASK);
                nxt.v = |(operand & OVF_MASK);
            end
            CMD_LDA:
            begin
                nxt.acc = operand;
                nz_val  = operand;
                nz_upd  = 1'b1;
            end
            CMD_LDX:
            begin
                nxt.x  = operand;
                nz_val = operand;
                nz_upd = 1'b1;
            end
            CMD_LDY:
            begin
                nxt.y  = operand;
                nz_val = operand;
                nz_upd = 1'b1;
            end
            CMD_STA:
            begin
                wr.write_data  = cur.acc;
                wr.write_valid = 1'b1;
            end
            CMD_STX:
            begin
                wr.write_data  = cur.x;
                wr.write_valid = 1'b1;
            end
            CMD_STY:
            begin
                wr.write_data  = cur.y;
                wr.write_valid = 1'b1;
            end
            CMD_ASL, CMD_LSR, CMD_ROL, CMD_ROR:
            begin
                nxt.c  = sh_carry;
                nz_val = sh_res;
                nz_upd = 1'b1;
                if (on_accumulator)
                begin
                    nxt.acc = sh_res;
                end
                else
                begin
                    wr.write_data  = sh_res;
                    wr.write_valid = 1'b1;
                end
            end
            CMD_INC:
            begin
                nz_val         = operand + 8'd1;
                nz_upd         = 1'b1;
                wr.write_data  = nz_val;
                wr.write_valid = 1'b1;
            end
            CMD_DEC:
            begin
                nz_val         = operand - 8'd1;
                nz_upd         = 1'b1;
                wr.write_data  = nz_val;
                wr.write_valid = 1'b1;
            end
            CMD_TAX:
            begin
                nxt.x  = cur.acc;
                nz_val = cur.acc;
                nz_upd = 1'b1;
            end
            CMD_TAY:
            begin
                nxt.y  = cur.acc;
                nz_val = cur.acc;
                nz_upd = 1'b1;
            end
            CMD_TXA:
            begin
                nxt.acc = cur.x;
                nz_val  = cur.x;
                nz_upd  = 1'b1;
            end
            CMD_TYA:
            begin
                nxt.acc = cur.y;
                nz_val  = cur.y;
                nz_upd  = 1'b1;
            end
            CMD_INX:
            begin
                nxt.x  = cur.x + 8'd1;
                nz_val = nxt.x;
                nz_upd = 1'b1;
            end
            CMD_DEX:
            begin
                nxt.x  = cur.x - 8'd1;
                nz_val = nxt.x;
                nz_upd = 1'b1;
            end
            CMD_INY:
            begin
                nxt.y  = cur.y + 8'd1;
                nz_val = nxt.y;
                nz_upd = 1'b1;
            end
            CMD_DEY:
            begin
                nxt.y  = cur.y - 8'd1;
                nz_val = nxt.y;
                nz_upd = 1'b1;
            end
            CMD_CLC: nxt.c = 1'b0;
            CMD_SEC: nxt.c = 1'b1;
            CMD_CLV: nxt.v = 1'b0;
            CMD_CLD: nxt.d = 1'b0;
            CMD_SED: nxt.d = 1'b1;
            CMD_CLI: nxt.i = 1'b0;
            CMD_SEI: nxt.i = 1'b1;
            default: ;
        endcase
        if (nz_upd)
        begin
            nxt.n = |(nz_val & SIGN_MASK);
            nxt.z = (nz_val == '0);
        end
    end

endmodule

### design/accumulator_alu_flag_unit.sv
// Executes one pre-decoded 8-bit instruction per word against internal A, X, Y and
// flags. A word is held in the input register and is executed while it moves to the
// result register. A new word is taken every cycle unless a word waits in the input
// register while the result register is full and m_tready is low; the alu path and the
// state update are combinational. ADC and SBC are binary whatever the D flag holds.
// Depends on aafu_pkg and aafu_alu.
module accumulator_alu_flag_unit (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          s_tvalid,
    output logic                          s_tready,
    // command[5:0], operand[13:6], zero fill
    input  logic [aafu_pkg::S_DATA_W-1:0] s_tdata,
    // on_accumulator
    input  logic                          s_tuser,
    output logic                          m_tvalid,
    input  logic                          m_tready,
    // write_data[7:0], write_valid[8], acc_out[16:9], x_out[24:17], y_out[32:25],
    // status_out[40:33], zero fill
    output logic [aafu_pkg::M_DATA_W-1:0] m_tdata
);
    import aafu_pkg::*;

    logic              in_valid_reg;
    logic [CMD_W-1:0]  in_cmd_reg;
    logic [BYTE_W-1:0] in_operand_reg;
    logic              in_on_acc_reg;
    logic              out_valid_reg;
    logic [M_DATA_W-1:0] out_data_reg;
    logic [M_DATA_W-1:0] out_data_next;
    arch_t             state_reg;
    arch_t             state_next;
    mem_wr_t           wr;
    logic              advance;
    logic              s_fire;

    assign advance  = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || advance;
    assign s_fire   = s_tvalid && s_tready;
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;

    aafu_alu u_alu (
        .command        (in_cmd_reg),
        .operand        (in_operand_reg),
        .on_accumulator (in_on_acc_reg),
        .cur            (state_reg),
        .nxt            (state_next),
        .wr             (wr)
    );

    assign out_data_next = {{(M_DATA_W - 5*BYTE_W - 1){1'b0}}, pack_status(state_next),
                            state_next.y, state_next.x, state_next.acc,
                            wr.write_valid, wr.write_data};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            state_reg     <= '0;
        end
        else
        begin
            if (s_fire)
            begin
                in_valid_reg <= 1'b1;
            end
            else if (advance)
            begin
                in_valid_reg <= 1'b0;
            end
            if (advance)
            begin
                out_valid_reg <= 1'b1;
                state_reg     <= state_next;
            end
            else if (m_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_fire)
        begin
            in_cmd_reg     <= s_tdata[CMD_W-1:0];
            in_operand_reg <= s_tdata[CMD_W+BYTE_W-1:CMD_W];
            in_on_acc_reg  <= s_tuser;
        end
        if (advance)
        begin
            out_data_reg <= out_data_next;
        end
    end

    // status bits 5 and 4 never set
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> (m_tdata[38:37] == 2'b00))
        else $error("reserved status bits set");

    // no write means zero write data
    assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && !m_tdata[8]) |-> (m_tdata[7:0] == '0))
        else $error("write data without write valid");

    // empty result register never blocks the input side
    assert property (@(posedge clk) disable iff (!rst_n)
        !out_valid_reg |-> s_tready)
        else $error("input stalled with empty result register");

    // clear carry reaches the kept state
    assert property (@(posedge clk) disable iff (!rst_n)
        (advance && (in_cmd_reg == CMD_CLC)) |=> !state_reg.c)
        else $error("carry not cleared");

    // state only moves when a word advances
    assert property (@(posedge clk) disable iff (!rst_n)
        !$past(advance) |-> $stable(state_reg))
        else $error("state changed without a word");

endmodule

### dv/tb.sv
// testbench for accumulator_alu_flag_unit: directed and random instruction words,
// predicted against a behavioral copy of A, X, Y and flags, with random idling on both sides
// depends on aafu_pkg and the design sources
`timescale 1ns / 1ps

module tb;
    import aafu_pkg::*;

    localparam int CLK_HALF     = 6;
    localparam int LIMIT_CYCLES = 200000;
    localparam int DRAIN_CYCLES = 8;
    localparam int SEGMENTS     = 15;
    localparam int SEG_WORDS    = 50;

    typedef struct packed {
        logic [BYTE_W-1:0] write_data;
        logic              write_valid;
        logic [BYTE_W-1:0] acc;
        logic [BYTE_W-1:0] x;
        logic [BYTE_W-1:0] y;
        logic [BYTE_W-1:0] status;
    } result_t;

    logic                clk = 1'b0;
    logic                rst_n = 1'b0;
    logic                s_tvalid = 1'b0;
    logic                s_tready;
    logic [S_DATA_W-1:0] s_tdata = '0;
    logic                s_tuser = 1'b0;
    logic                m_tvalid;
    logic                m_tready = 1'b0;
    logic [M_DATA_W-1:0] m_tdata;

    arch_t   arch_regs = '0;
    result_t pending_results[$];
    int      error_count = 0;
    int      cycle_count = 0;
    int      burst_left = 0;
    bit      gaps_on = 1'b1;
    int      rx_mode = 0;
    logic [31:0] rx_count = '0;

    accumulator_alu_flag_unit u_dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    always
    begin
        #CLK_HALF clk = 1'b1;
        #CLK_HALF clk = 1'b0;
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= LIMIT_CYCLES)
        begin
            $display("CHECKS FAILED");
            $finish;
        end
    end

    // behavioral instruction execution

    function automatic void update_nz(input logic [BYTE_W-1:0] val);
        arch_regs.n = val[7];
        arch_regs.z = (val == '0);
    endfunction

    function automatic logic [BYTE_W-1:0] add_carry(input logic [BYTE_W-1:0] a,
                                                    input logic [BYTE_W-1:0] m);
        logic [BYTE_W:0]   sum;
        logic [BYTE_W-1:0] r;
        sum = {1'b0, a} + {1'b0, m} + {8'd0, arch_regs.c};
        r = sum[BYTE_W-1:0];
        arch_regs.c = sum[BYTE_W];
        arch_regs.v = ((a ^ r) & (m ^ r) & SIGN_MASK) != '0;
        update_nz(r);
        return r;
    endfunction

    function automatic void compare_reg(input logic [BYTE_W-1:0] reg_val,
                                        input logic [BYTE_W-1:0] m);
        arch_regs.c = (reg_val >= m);
        update_nz(reg_val - m);
    endfunction

    function automatic result_t predict_word(input logic [CMD_W-1:0] command,
                                             input logic [BYTE_W-1:0] operand,
                                             input logic on_acc);
        result_t           res;
        logic [BYTE_W-1:0] v;
        logic [BYTE_W-1:0] r;
        res = '0;
        case (command)
            CMD_ORA: begin arch_regs.acc = arch_regs.acc | operand; update_nz(arch_regs.acc); end
            CMD_AND: begin arch_regs.acc = arch_regs.acc & operand; update_nz(arch_regs.acc); end
            CMD_EOR: begin arch_regs.acc = arch_regs.acc ^ operand; update_nz(arch_regs.acc); end
            CMD_ADC: arch_regs.acc = add_carry(arch_regs.acc, operand);
            CMD_SBC: arch_regs.acc = add_carry(arch_regs.acc, ~operand);
            CMD_CMP: compare_reg(arch_regs.acc, operand);
            CMD_CPX: compare_reg(arch_regs.x, operand);
            CMD_CPY: compare_reg(arch_regs.y, operand);
            CMD_BIT:
            begin
                arch_regs.z = (arch_regs.acc & operand) == '0;
                arch_regs.n = (operand & SIGN_MASK) != '0;
                arch_regs.v = (operand & OVF_MASK) != '0;
            end
            CMD_LDA: begin arch_regs.acc = operand; update_nz(operand); end
            CMD_LDX: begin arch_regs.x = operand; update_nz(operand); end
            CMD_LDY: begin arch_regs.y = operand; update_nz(operand); end
            CMD_STA: begin res.write_data = arch_regs.acc; res.write_valid = 1'b1; end
            CMD_STX: begin res.write_data = arch_regs.x; res.write_valid = 1'b1; end
            CMD_STY: begin res.write_data = arch_regs.y; res.write_valid = 1'b1; end
            CMD_ASL, CMD_LSR, CMD_ROL, CMD_ROR:
            begin
                v = on_acc ? arch_regs.acc : operand;
                case (command)
                    CMD_ASL: r = {v[6:0], 1'b0};
                    CMD_LSR: r = {1'b0, v[7:1]};
                    CMD_ROL: r = {v[6:0], arch_regs.c};
                    default: r = {arch_regs.c, v[7:1]};
                endcase
                arch_regs.c = (command == CMD_ASL || command == CMD_ROL) ?
                              (v & SIGN_MASK) != '0 : (v & LSB_MASK) != '0;
                update_nz(r);
                if (on_acc)
                    arch_regs.acc = r;
                else
                begin
                    res.write_data  = r;
                    res.write_valid = 1'b1;
                end
            end
            CMD_INC:
            begin
                r = operand + 8'd1;
                update_nz(r);
                res.write_data  = r;
                res.write_valid = 1'b1;
            end
            CMD_DEC:
            begin
                r = operand - 8'd1;
                update_nz(r);
                res.write_data  = r;
                res.write_valid = 1'b1;
            end
            CMD_TAX: begin arch_regs.x = arch_regs.acc; update_nz(arch_regs.x); end
            CMD_TAY: begin arch_regs.y = arch_regs.acc; update_nz(arch_regs.y); end
            CMD_TXA: begin arch_regs.acc = arch_regs.x; update_nz(arch_regs.acc); end
            CMD_TYA: begin arch_regs.acc = arch_regs.y; update_nz(arch_regs.acc); end
            CMD_INX: begin arch_regs.x = arch_regs.x + 8'd1; update_nz(arch_regs.x); end
            CMD_DEX: begin arch_regs.x = arch_regs.x - 8'd1; update_nz(arch_regs.x); end
            CMD_INY: begin arch_regs.y = arch_regs.y + 8'd1; update_nz(arch_regs.y); end
            CMD_DEY: begin arch_regs.y = arch_regs.y - 8'd1; update_nz(arch_regs.y); end
            CMD_CLC: arch_regs.c = 1'b0;
            CMD_SEC: arch_regs.c = 1'b1;
            CMD_CLV: arch_regs.v = 1'b0;
            CMD_CLD: arch_regs.d = 1'b0;
            CMD_SED: arch_regs.d = 1'b1;
            CMD_CLI: arch_regs.i = 1'b0;
            CMD_SEI: arch_regs.i = 1'b1;
            default: ;
        endcase
        res.acc    = arch_regs.acc;
        res.x      = arch_regs.x;
        res.y      = arch_regs.y;
        res.status = {arch_regs.n, arch_regs.v, 2'b00,
                      arch_regs.d, arch_regs.i, arch_regs.z, arch_regs.c};
        return res;
    endfunction

    // sender: entered and left at a falling edge

    task automatic send_word(input logic [CMD_W-1:0] command, input logic [BYTE_W-1:0] operand,
                             input logic on_acc);
        int gap;
        if (burst_left == 0)
        begin
            burst_left = $urandom_range(1, 16);
            gap = gaps_on ? $urandom_range(0, 5) : 0;
            if (gap > 0)
            begin
                s_tvalid <= 1'b0;
                repeat (gap) @(negedge clk);
            end
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {2'b00, operand, command};
        s_tuser  <= on_acc;
        do
            @(posedge clk);
        while (!s_tready);
        pending_results.push_back(predict_word(command, operand, on_acc));
        burst_left--;
        @(negedge clk);
    endtask

    task automatic wait_for_results();
        s_tvalid <= 1'b0;
        do
            @(negedge clk);
        while (pending_results.size() != 0);
    endtask

    // receiver stall pattern

    always @(negedge clk)
    begin
        if (rst_n)
        begin
            rx_count <= rx_count + 1;
            if (rx_count % 48 == 0)
                rx_mode <= $urandom_range(0, 2);
            case (rx_mode)
                0:       m_tready <= 1'b1;
                1:       m_tready <= 1'($urandom_range(0, 1));
                default: m_tready <= (rx_count[1:0] == 2'b00);
            endcase
        end
    end

    // result checking

    task automatic check_field(input string name, input logic [BYTE_W-1:0] want,
                               input logic [BYTE_W-1:0] got);
        if (got !== want)
        begin
            $display("%0t: %s mismatch, expected %h actual %h", $time, name, want, got);
            error_count++;
        end
    endtask

    always @(posedge clk)
    begin
        result_t want;
        if (rst_n && m_tvalid && m_tready)
        begin
            if (pending_results.size() == 0)
            begin
                $display("%0t: unexpected word, expected none actual %h", $time, m_tdata);
                error_count++;
            end
            else
            begin
                want = pending_results.pop_front();
                check_field("write_data", want.write_data, m_tdata[7:0]);
                check_field("write_valid", {7'd0, want.write_valid}, {7'd0, m_tdata[8]});
                check_field("acc_out", want.acc, m_tdata[16:9]);
                check_field("x_out", want.x, m_tdata[24:17]);
                check_field("y_out", want.y, m_tdata[32:25]);
                check_field("status_out", want.status, m_tdata[40:33]);
            end
        end
    end

    // tests

    task automatic test_arith_flags();
        send_word(CMD_SED, 8'h00, 1'b0);
        send_word(CMD_LDA, 8'h7F, 1'b0);
        // signed overflow with decimal set, still binary
        send_word(CMD_ADC, 8'h01, 1'b0);
        send_word(CMD_SBC, 8'hFF, 1'b1);
        send_word(CMD_SEC, 8'h00, 1'b0);
        send_word(CMD_ADC, 8'hFF, 1'b0);
        send_word(CMD_CMP, 8'h80, 1'b0);
        send_word(CMD_LDX, 8'hFF, 1'b0);
        send_word(CMD_INX, 8'h00, 1'b0);
        send_word(CMD_CPX, 8'h00, 1'b0);
        send_word(CMD_LDY, 8'h00, 1'b0);
        send_word(CMD_DEY, 8'h00, 1'b0);
        send_word(CMD_CPY, 8'hFF, 1'b0);
        send_word(CMD_BIT, 8'hC0, 1'b0);
        send_word(CMD_CLV, 8'h00, 1'b0);
    endtask

    task automatic test_shifts_and_writes();
        send_word(CMD_STA, 8'hFF, 1'b0);
        send_word(CMD_STX, 8'h00, 1'b1);
        send_word(CMD_STY, 8'h55, 1'b0);
        // shift on accumulator, no memory write
        send_word(CMD_ASL, 8'hFF, 1'b1);
        send_word(CMD_ROR, 8'h01, 1'b0);
        send_word(CMD_LSR, 8'hFF, 1'b0);
        send_word(CMD_ROL, 8'h80, 1'b1);
        // inc and dec ignore the accumulator flag
        send_word(CMD_INC, 8'hFF, 1'b1);
        send_word(CMD_DEC, 8'h00, 1'b1);
    endtask

    task automatic test_transfers_and_unused();
        send_word(CMD_TAX, 8'h00, 1'b0);
        send_word(CMD_TYA, 8'h00, 1'b0);
        send_word(CMD_SEI, 8'h00, 1'b0);
        // unused code behaves as nop
        send_word(6'd63, 8'hFF, 1'b1);
        send_word(CMD_CLD, 8'h00, 1'b0);
        send_word(CMD_CLI, 8'h00, 1'b0);
    endtask

    task automatic test_random_stream();
        int               seg;
        int               k;
        logic [CMD_W-1:0] command;
        logic [BYTE_W-1:0] operand;
        for (seg = 0; seg < SEGMENTS; seg++)
        begin
            gaps_on = ($urandom_range(0, 3) != 0);
            // hold off until the block has drained
            if (seg == SEGMENTS / 2)
                wait_for_results();
            for (k = 0; k < SEG_WORDS; k++)
            begin
                if ($urandom_range(0, 9) == 0)
                    command = CMD_W'($urandom_range(37, 63));
                else
                    command = CMD_W'($urandom_range(0, 36));
                case ($urandom_range(0, 5))
                    0:       operand = 8'h00;
                    1:       operand = 8'hFF;
                    2:       operand = 8'h80;
                    3:       operand = 8'h7F;
                    default: operand = BYTE_W'($urandom);
                endcase
                send_word(command, operand, 1'($urandom_range(0, 1)));
            end
        end
    endtask

    initial
    begin
        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);
        test_arith_flags();
        test_shifts_and_writes();
        test_transfers_and_unused();
        test_random_stream();
        wait_for_results();
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (error_count == 0 && pending_results.size() == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule

### accumulator_alu_flag_unit.f
design/aafu_pkg.sv
design/aafu_alu.sv
design/accumulator_alu_flag_unit.sv
dv/tb.sv
